FILE: rtl/core/fcf_pkg.sv
// Package for the feedback comb filter: default parameters, field widths,
// register codes and the APB address width. No dependencies.

package fcf_pkg;

  localparam int DEF_MAX_DELAY    = 4096;
  localparam int DEF_SAMPLE_WIDTH = 24;

  // Q1.16 gain
  localparam int GAIN_WIDTH = 18;
  localparam int GAIN_ONE   = 65536;
  localparam int FRAC_BITS  = 16;

  // width of the delay_length register field
  localparam int DELAY_CFG_WIDTH = 13;

  // APB: two registers at byte addresses 0 and 4
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index, taken from paddr[2]
  localparam logic REG_GAIN  = 1'b0;
  localparam logic REG_DELAY = 1'b1;

endpackage

FILE: rtl/core/fcf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first on an address collision. No dependencies.

module fcf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/fcf_cfg.sv
// APB register block of the comb filter: gain and delay length, with
// clamping on write and a store clear pulse on a delay write. Uses fcf_pkg.

module fcf_cfg
  import fcf_pkg::*;
#(
  parameter int MAX_DELAY = DEF_MAX_DELAY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [APB_AW-1:0]                   paddr,
  input  logic [APB_DW-1:0]                   pwdata,
  output logic [APB_DW-1:0]                   prdata,
  output logic                                pready,
  output logic signed [GAIN_WIDTH-1:0]        gain,
  output logic [$clog2(MAX_DELAY+1)-1:0]      delay_len,
  output logic                                store_clear
);

  localparam int LW = $clog2(MAX_DELAY + 1);
  localparam logic signed [GAIN_WIDTH-1:0] GMAX = GAIN_WIDTH'(GAIN_ONE);
  localparam logic signed [GAIN_WIDTH-1:0] GMIN = -GMAX;

  logic                         wr;
  logic                         idx;
  logic signed [GAIN_WIDTH-1:0] wgain;
  logic [31:0]                  wdelay;
  logic signed [GAIN_WIDTH-1:0] gain_next;
  logic [LW-1:0]                delay_len_next;

  assign pready = 1'b1;
  assign idx    = paddr[2];
  assign wr     = psel && penable && pwrite && pready;
  assign store_clear = wr && (idx == REG_DELAY);

  assign wgain  = $signed(pwdata[GAIN_WIDTH-1:0]);
  assign wdelay = 32'(pwdata[DELAY_CFG_WIDTH-1:0]);

  always_comb begin
    if (wgain > GMAX) begin
      gain_next = GMAX;
    end else if (wgain < GMIN) begin
      gain_next = GMIN;
    end else begin
      gain_next = wgain;
    end
    // zero acts as one, anything past the store acts as full length
    if (wdelay == 32'd0) begin
      delay_len_next = LW'(1);
    end else if (wdelay > 32'(MAX_DELAY)) begin
      delay_len_next = LW'(MAX_DELAY);
    end else begin
      delay_len_next = LW'(wdelay);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= '0;
      delay_len <= LW'(1);
    end else if (wr) begin
      case (idx)
        REG_GAIN:  gain      <= gain_next;
        REG_DELAY: delay_len <= delay_len_next;
        default:   gain      <= gain;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN:  prdata = APB_DW'(gain);
      REG_DELAY: prdata = APB_DW'(delay_len);
      default:   prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/fcf_mac.sv
// Output stage arithmetic: floor of the Q1.16 feedback product, add of the
// input sample and saturation to the sample range. Uses fcf_pkg.

module fcf_mac
  import fcf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic signed [SAMPLE_WIDTH-1:0]            x,
  input  logic signed [SAMPLE_WIDTH+GAIN_WIDTH-1:0] prod,
  output logic signed [SAMPLE_WIDTH-1:0]            y
);

  localparam int PW   = SAMPLE_WIDTH + GAIN_WIDTH;
  localparam int SUMW = PW + 1;
  localparam logic signed [SUMW-1:0] SMAX = SUMW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUMW-1:0] SMIN = -SMAX - SUMW'(1);

  logic signed [PW-1:0]   fb;
  logic signed [SUMW-1:0] sum;

  // arithmetic shift rounds toward negative infinity
  assign fb  = prod >>> FRAC_BITS;
  assign sum = SUMW'(x) + SUMW'(fb);

  always_comb begin
    if (sum > SMAX) begin
      y = SMAX[SAMPLE_WIDTH-1:0];
    end else if (sum < SMIN) begin
      y = SMIN[SAMPLE_WIDTH-1:0];
    end else begin
      y = sum[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

FILE: rtl/core/feedback_comb_filter.sv
// Feedback comb filter top level: y = sat(x + floor(g * y[n-L] / 2^16)).
// Depends on fcf_pkg, fcf_ram, fcf_cfg and fcf_mac.
//
// One output word per input word. Each accepted word passes the read stage
// (read and multiply), then the write-back stage (add/saturate/write-back),
// into the output register. The read stage holds one word while the delay
// store is read, and no new input word is taken until it is empty. A word
// with a delay of one sample needs the write-back of the word before it,
// which is forwarded from the write port. The finished result waits in an
// output register, so the next input word is taken while it is pending.
// Past outputs live in one MAX_DELAY-deep RAM. There is no clearing pass:
// a fill count of words since the last clear marks which entries are real,
// and entries not yet written read as zero. Reset and any write to
// delay_length (byte address 4) restart that history; feedback_gain lives
// at byte address 0 and is clamped to -1.0..1.0 in Q1.16. Write the
// registers only while no word is in flight.

module feedback_comb_filter
  import fcf_pkg::*;
#(
  parameter int MAX_DELAY    = DEF_MAX_DELAY,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,   // [SAMPLE_WIDTH-1:0] sample_in
  // output stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    m_tdata,   // [SAMPLE_WIDTH-1:0] sample_out
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [APB_AW-1:0]                    paddr,
  input  logic [APB_DW-1:0]                    pwdata,
  output logic [APB_DW-1:0]                    prdata,
  output logic                                 pready
);

  localparam int AW = $clog2(MAX_DELAY);
  localparam int LW = $clog2(MAX_DELAY + 1);
  localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int PW = SAMPLE_WIDTH + GAIN_WIDTH;

  // configuration
  logic signed [GAIN_WIDTH-1:0] gain;
  logic [LW-1:0]                delay_len;
  logic                         store_clear;

  // history pointers
  logic [AW-1:0] wp;
  logic [AW-1:0] wp_next;
  logic [LW-1:0] fill;
  logic [LW-1:0] wp_l;
  logic [AW-1:0] rd;

  // handshakes
  logic accept;
  logic adv1;
  logic adv2;

  // read stage
  logic                           v1;
  logic signed [SAMPLE_WIDTH-1:0] x1;
  logic [AW-1:0]                  waddr1;
  logic                           hit1;
  logic                           fwd1;
  logic signed [SAMPLE_WIDTH-1:0] fwd_data1;
  logic [SAMPLE_WIDTH-1:0]        rdata;
  logic signed [SAMPLE_WIDTH-1:0] d1;
  logic signed [PW-1:0]           prod1;

  // write-back stage
  logic                           v2;
  logic signed [SAMPLE_WIDTH-1:0] x2;
  logic signed [PW-1:0]           prod2;
  logic [AW-1:0]                  waddr2;
  logic signed [SAMPLE_WIDTH-1:0] y2;

  fcf_cfg #(
    .MAX_DELAY (MAX_DELAY)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .gain        (gain),
    .delay_len   (delay_len),
    .store_clear (store_clear)
  );

  // pipeline control: the read stage holds one word, and it only enters
  // when the word ahead of it writes back at the same edge or earlier
  assign adv2     = v2 && (!m_tvalid || m_tready);
  assign adv1     = v1 && (!v2 || adv2);
  assign s_tready = !v1 && (!v2 || adv2);
  assign accept   = s_tvalid && s_tready;

  // read address = wp - L modulo the store depth
  assign wp_l = LW'(wp);
  always_comb begin
    if (wp_l >= delay_len) begin
      rd = AW'(wp_l - delay_len);
    end else begin
      rd = AW'(wp_l + LW'(MAX_DELAY) - delay_len);
    end
  end

  assign wp_next = (wp == AW'(MAX_DELAY - 1)) ? '0 : wp + AW'(1);

  always_ff @(posedge clk) begin
    if (rst || store_clear) begin
      wp   <= '0;
      fill <= '0;
    end else if (accept) begin
      wp <= wp_next;
      if (fill != LW'(MAX_DELAY)) begin
        fill <= fill + LW'(1);
      end
    end
  end

  fcf_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_DELAY)
  ) u_store (
    .clk   (clk),
    .we    (adv2),
    .waddr (waddr2),
    .wdata (y2),
    .re    (accept),
    .raddr (rd),
    .rdata (rdata)
  );

  // read stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (accept) begin
      v1 <= 1'b1;
    end else if (adv1) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1        <= $signed(s_tdata[SAMPLE_WIDTH-1:0]);
      waddr1    <= wp;
      // entry was written since the last clear (or is being written now)
      hit1      <= (fill >= delay_len);
      // previous word writes the entry we read at this same edge
      fwd1      <= adv2 && (waddr2 == rd);
      fwd_data1 <= y2;
    end
  end

  always_comb begin
    if (fwd1) begin
      d1 = fwd_data1;
    end else if (hit1) begin
      d1 = $signed(rdata);
    end else begin
      d1 = '0;
    end
  end

  assign prod1 = PW'(d1) * PW'(gain);

  // write-back stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv1) begin
      v2 <= 1'b1;
    end else if (adv2) begin
      v2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      x2     <= x1;
      prod2  <= prod1;
      waddr2 <= waddr1;
    end
  end

  fcf_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .x    (x2),
    .prod (prod2),
    .y    (y2)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv2) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      m_tdata <= DW'($unsigned(y2));
    end
  end

endmodule

FILE: test/tb_feedback_comb_filter.sv
// Self-checking testbench for feedback_comb_filter: streams samples in, checks every output word
// against an in-bench predictor of y = sat(x + floor(g * y[n-L] / 2^16)).
// Depends on fcf_pkg and the feedback_comb_filter RTL.
`timescale 1ns / 100ps

module tb_feedback_comb_filter;
  import fcf_pkg::*;

  localparam int SW    = DEF_SAMPLE_WIDTH;
  localparam int DEPTH = DEF_MAX_DELAY;
  localparam int DW    = ((SW + 7) / 8) * 8;
  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  // Comb filter predictor plus the queue of output words still owed by the DUT.
  class comb_scoreboard;
    int          gain;
    int          delay_len;
    int          history [DEPTH];
    int          wr_ptr;
    logic [SW-1:0] owed [$];
    int          errors;

    function new();
      gain      = 0;
      delay_len = 1;
      errors    = 0;
      clear_history();
    endfunction

    function void clear_history();
      foreach (history[i]) history[i] = 0;
      wr_ptr = 0;
    endfunction

    // register write as seen by the block: gain clamps to +-1.0, delay clamps to 1..DEPTH
    // and any delay write restarts the history
    function void write_reg(logic sel, logic [APB_DW-1:0] value);
      longint g;
      int     d;
      if (sel == REG_GAIN) begin
        g = longint'($signed(value[GAIN_WIDTH-1:0]));
        if (g > GAIN_ONE) g = GAIN_ONE;
        if (g < -GAIN_ONE) g = -GAIN_ONE;
        gain = int'(g);
      end else begin
        d = int'(value[DELAY_CFG_WIDTH-1:0]);
        if (d < 1) d = 1;
        if (d > DEPTH) d = DEPTH;
        delay_len = d;
        clear_history();
      end
    endfunction

    // accepted input word: compute its output and advance the delay line
    function void note_sample(logic [SW-1:0] x);
      longint fb;
      longint y;
      int     rd;
      rd = (wr_ptr + DEPTH - delay_len) % DEPTH;
      fb = (longint'(history[rd]) * gain) >>> FRAC_BITS;  // floor toward -inf
      y  = longint'($signed(x)) + fb;
      if (y > longint'($signed(S_MAX))) y = longint'($signed(S_MAX));
      if (y < longint'($signed(S_MIN))) y = longint'($signed(S_MIN));
      history[wr_ptr] = int'(y);
      wr_ptr = (wr_ptr + 1) % DEPTH;
      owed.push_back(y[SW-1:0]);
    endfunction

    function void check_sample(logic [SW-1:0] got);
      logic [SW-1:0] want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected output word, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = owed.pop_front();
        if (got !== want) begin
          $display("%0t: sample_out mismatch, expected %h, actual %h", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [DW-1:0]     s_tdata;    // [SW-1:0] sample_in
  logic              m_tvalid;
  logic              m_tready = 1'b1;
  logic [DW-1:0]     m_tdata;    // [SW-1:0] sample_out
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  comb_scoreboard sb = new();

  bit quiet;            // set for the tail of the run: no idling on either side
  int stall_left = 0;   // remaining cycles of the current m_tready stall

  feedback_comb_filter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Hard stop in case the DUT hangs; well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("** feedback_comb_filter: FAILED **");
    $finish;
  end

  // Sink side: random backpressure bursts, changed on the falling edge only.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 5);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Output monitor: a word moves when tvalid and tready are both high at the rising edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_sample(m_tdata[SW-1:0]);
  end

  // Both driver tasks are entered and left on a falling edge.

  // One APB write: setup cycle, then access cycle; the register takes it at the
  // rising edge with psel/penable/pwrite/pready all high. The bus then idles.
  task automatic apb_write(input logic sel, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(sel, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // One input word, with an optional random gap in front of it. tvalid stays high
  // after acceptance so back-to-back words need no idle gap.
  task automatic send_sample(input logic [SW-1:0] x);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= DW'(x);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_sample(x);
    @(negedge clk);
  endtask

  // Drop tvalid and wait until every owed word is out, then let the pipeline
  // sit idle before any register write.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return SW'($urandom_range(0, 400) - 200);
      default: return SW'($urandom);
    endcase
  endfunction

  // Gain values, upper pwdata bits random (the block only looks at the low 18).
  function automatic logic [APB_DW-1:0] pick_gain();
    logic [APB_DW-1:0] r;
    int                g;
    r = $urandom;
    case ($urandom_range(0, 5))
      0:       g = GAIN_ONE;
      1:       g = -GAIN_ONE;
      2:       g = int'($urandom);                       // any 18-bit code, out-of-range ones clamp
      3:       g = $urandom_range(0, 2048) - 1024;
      default: g = $urandom_range(0, 2 * GAIN_ONE) - GAIN_ONE;
    endcase
    r[GAIN_WIDTH-1:0] = g[GAIN_WIDTH-1:0];
    return r;
  endfunction

  // Mostly short delays so feedback builds up quickly.
  function automatic logic [APB_DW-1:0] pick_delay();
    logic [APB_DW-1:0] r;
    int                d;
    r = $urandom;
    case ($urandom_range(0, 7))
      0:       d = 0;
      1:       d = $urandom_range(DEPTH + 1, 8191);
      2:       d = $urandom_range(9, 64);
      default: d = $urandom_range(1, 8);
    endcase
    r[DELAY_CFG_WIDTH-1:0] = d[DELAY_CFG_WIDTH-1:0];
    return r;
  endfunction

  task automatic run_phase(input int n, input bit pause_mid);
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) drain();
      send_sample(pick_sample());
    end
    drain();
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    quiet      = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset defaults: gain 0, so output equals input.
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample('0);
    send_sample('1);
    drain();

    // Unity feedback, delay 1: sums run into both saturation limits.
    apb_write(REG_GAIN, 32'h0001_0000);
    apb_write(REG_DELAY, 32'd1);
    send_sample(S_MAX);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MIN);
    send_sample(S_MIN);
    drain();

    // Gain code above +1.0 clamps; delay 0 behaves as 1.
    apb_write(REG_GAIN, 32'h0001_FFFF);
    apb_write(REG_DELAY, 32'd0);
    send_sample(SW'(32'h40_0000));
    send_sample(SW'(32'h40_0000));
    drain();

    // Most negative gain code clamps to -1.0; delay 2.
    apb_write(REG_GAIN, 32'h0002_0000);
    apb_write(REG_DELAY, 32'd2);
    send_sample(SW'(1000));
    send_sample(SW'(2000));
    send_sample('0);
    send_sample('0);
    drain();

    // Gain of -1 lsb: floor rounding turns tiny products into -1. Rewriting
    // delay with an unchanged value still clears the history.
    apb_write(REG_DELAY, 32'd1);
    apb_write(REG_DELAY, 32'd1);
    apb_write(REG_GAIN, 32'h0003_FFFF);
    send_sample(SW'(5));
    send_sample(SW'(5));
    send_sample(SW'(5));
    drain();

    // Delays past the store depth clamp to the full depth.
    apb_write(REG_GAIN, 32'h0001_0000);
    apb_write(REG_DELAY, 32'h1FFF);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(SW'(7));
    drain();
    apb_write(REG_DELAY, DEPTH + 1);
    send_sample(S_MAX);
    send_sample(SW'(3));
    drain();

    // Random phases with fresh settings each time; one pauses mid-stream
    // until the DUT has caught up completely.
    for (int p = 0; p < 5; p++) begin
      apb_write(REG_GAIN, pick_gain());
      apb_write(REG_DELAY, pick_delay());
      run_phase($urandom_range(80, 120), p == 2);
    end

    // Full-depth delay: every read lands on an entry not yet written since
    // the clear, so the feedback must stay zero.
    apb_write(REG_GAIN, 32'hFFFF_8000);   // -0.5
    apb_write(REG_DELAY, DEPTH);
    run_phase(100, 1'b0);

    // Tail: no idling on either side.
    quiet = 1'b1;
    apb_write(REG_GAIN, pick_gain());
    apb_write(REG_DELAY, 32'd1);
    run_phase(100, 1'b0);

    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** feedback_comb_filter: PASSED **");
    end else begin
      $display("** feedback_comb_filter: FAILED **");
    end
    $finish;
  end

endmodule
